// ----- design/awrs_pkg.sv -----
`default_nettype none
package awrs_pkg;

  localparam int POS_W      = 7;
  localparam int PLANE_W    = 17;
  localparam int SLOT_W     = 4;
  localparam int WIN_PLANES = 11;
  localparam int HALF_ORDER = 5;
  localparam int NUM_TAPS   = 31;
  localparam int TAP_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int SUM_W      = 50;
  localparam int ACC_W      = 84;
  localparam int QUO_W      = 48;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DZ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DX = 3'd4;

  localparam logic [14:0] ROUND_CONST = 15'd12600;

  // divide by 25200: drop 4 bits, then multiply by ceil(2^53 / 1575)
  localparam int          RECIP_SHIFT  = 53;
  localparam logic [42:0] RECIP_CONST  = 43'd5718856669677;
  localparam logic [47:0] SAT_DIVIDEND = 48'd54116587954800;

  typedef logic [1:0] tap_kind_t;
  localparam tap_kind_t KIND_TIME   = 2'd0;
  localparam tap_kind_t KIND_X      = 2'd1;
  localparam tap_kind_t KIND_Z      = 2'd2;
  localparam tap_kind_t KIND_CENTER = 2'd3;

  typedef struct packed {
    logic signed [31:0] sample;
    logic [31:0]        slowness_term;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] residual;
    logic               last_point;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] depth;
    logic [POS_W-1:0] width;
    logic [15:0]      planes;
    logic [31:0]      inv_dz;
    logic [31:0]      inv_dx;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0]  sample;
    logic [31:0]         slowness;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    z;
    logic [PLANE_W-1:0]  plane;
    logic [SLOT_W-1:0]   slot;
    logic                has_result;
    logic                last;
  } job_t;

  typedef struct packed {
    tap_kind_t  kind;
    logic [2:0] k;
    logic       neg;
  } tap_info_t;

  function automatic tap_info_t tap_info(logic [TAP_W-1:0] t);
    tap_info_t  r;
    logic [TAP_W-1:0] u;
    if (t < 5'd10) begin
      r.kind = KIND_TIME;
      u = t;
    end else if (t < 5'd20) begin
      r.kind = KIND_X;
      u = t - 5'd10;
    end else if (t < 5'd30) begin
      r.kind = KIND_Z;
      u = t - 5'd20;
    end else begin
      r.kind = KIND_CENTER;
      u = '0;
    end
    r.k   = (r.kind == KIND_CENTER) ? 3'd0 : 3'(u >> 1) + 3'd1;
    r.neg = u[0];
    return r;
  endfunction

  function automatic logic signed [17:0] tap_weight(logic [2:0] k);
    logic signed [17:0] w;
    case (k)
      3'd0:    w = -18'sd73766;
      3'd1:    w = 18'sd42000;
      3'd2:    w = -18'sd6000;
      3'd3:    w = 18'sd1000;
      3'd4:    w = -18'sd125;
      3'd5:    w = 18'sd8;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- design/awrs_front.sv -----
`default_nettype none
module awrs_front #(
  parameter int MAX_DEPTH = 64,
  parameter int MAX_WIDTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire awrs_pkg::in_item_t                in_data,
  input  wire logic                              cfg_we,
  input  wire logic [awrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                       cfg_data,
  input  wire logic                              q_full,
  output logic                                   push,
  output awrs_pkg::job_t                         push_job,
  output awrs_pkg::cfg_t                         cfg
);

  localparam int P = awrs_pkg::POS_W;

  logic [P-1:0]                     depth_r, width_r;
  logic [15:0]                      time_r;
  logic [31:0]                      inv_dz_r, inv_dx_r;
  logic [P-1:0]                     z_r, x_r;
  logic [awrs_pkg::PLANE_W-1:0]     plane_r;
  logic [awrs_pkg::SLOT_W-1:0]      slot_r;
  logic [P-1:0]                     eff_d, eff_w;
  logic [15:0]                      eff_t;
  logic [awrs_pkg::PLANE_W-1:0]     plane_end;
  logic                             z_end, x_end, p_end, restart;

  always_comb begin
    if (depth_r == '0) begin
      eff_d = P'(1);
    end else if ({4'b0, depth_r} > 11'(MAX_DEPTH)) begin
      eff_d = P'(MAX_DEPTH);
    end else begin
      eff_d = depth_r;
    end
    if (width_r == '0) begin
      eff_w = P'(1);
    end else if ({4'b0, width_r} > 11'(MAX_WIDTH)) begin
      eff_w = P'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    eff_t = (time_r == '0) ? 16'd1 : time_r;
  end

  assign plane_end = {1'b0, eff_t} + 17'(awrs_pkg::HALF_ORDER - 1);
  assign z_end     = (z_r == eff_d - P'(1));
  assign x_end     = (x_r == eff_w - P'(1));
  assign p_end     = (plane_r == plane_end);
  assign in_ready  = !q_full;
  assign push      = in_valid && !q_full;
  assign restart   = cfg_we && (cfg_index inside {awrs_pkg::REG_DEPTH, awrs_pkg::REG_WIDTH,
                                                  awrs_pkg::REG_TIME});

  assign cfg.depth  = eff_d;
  assign cfg.width  = eff_w;
  assign cfg.planes = eff_t;
  assign cfg.inv_dz = inv_dz_r;
  assign cfg.inv_dx = inv_dx_r;

  always_comb begin
    push_job.sample     = (plane_r >= {1'b0, eff_t}) ? 32'sd0 : in_data.sample;
    push_job.slowness   = in_data.slowness_term;
    push_job.x          = x_r;
    push_job.z          = z_r;
    push_job.plane      = plane_r;
    push_job.slot       = slot_r;
    push_job.has_result = (plane_r >= 17'(awrs_pkg::HALF_ORDER));
    push_job.last       = p_end && x_end && z_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= P'(64);
      width_r  <= P'(64);
      time_r   <= 16'd1;
      inv_dz_r <= 32'd65536;
      inv_dx_r <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        awrs_pkg::REG_DEPTH:  depth_r  <= cfg_data[P-1:0];
        awrs_pkg::REG_WIDTH:  width_r  <= cfg_data[P-1:0];
        awrs_pkg::REG_TIME:   time_r   <= cfg_data[15:0];
        awrs_pkg::REG_INV_DZ: inv_dz_r <= cfg_data;
        awrs_pkg::REG_INV_DX: inv_dx_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      z_r     <= '0;
      x_r     <= '0;
      plane_r <= '0;
      slot_r  <= '0;
    end else if (push) begin
      if (z_end) begin
        z_r <= '0;
        if (x_end) begin
          x_r <= '0;
          if (p_end) begin
            plane_r <= '0;
            slot_r  <= '0;
          end else begin
            plane_r <= plane_r + 17'd1;
            slot_r  <= (slot_r == 4'(awrs_pkg::WIN_PLANES - 1)) ? '0 : slot_r + 4'd1;
          end
        end else begin
          x_r <= x_r + P'(1);
        end
      end else begin
        z_r <= z_r + P'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/awrs_queue.sv -----
`default_nettype none
module awrs_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire awrs_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output awrs_pkg::job_t      head
);

  localparam int D  = awrs_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);

  awrs_pkg::job_t  slots_r [D];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r;

  assign full      = (count_r == (PW+1)'(D));
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) slots_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop && not_empty) rd_ptr_r <= rd_ptr_r + PW'(1);
      count_r <= count_r + (PW+1)'(push && !full) - (PW+1)'(pop && not_empty);
    end
  end

endmodule
`default_nettype wire

// ----- design/awrs_div.sv -----
`default_nettype none
module awrs_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [awrs_pkg::QUO_W-1:0]  dividend,
  output logic                             done,
  output logic [awrs_pkg::QUO_W-1:0]       quotient
);

  localparam int QW = awrs_pkg::QUO_W;
  localparam int YW = 42;
  localparam int PW = 85;

  logic          busy_r, done_r;
  logic [1:0]    step_r;
  logic [YW-1:0] y_r;
  logic [PW-1:0] acc_r;
  logic [QW-1:0] clamped;
  logic [21:0]   m_part;
  logic [20:0]   y_part;
  logic [42:0]   pp;
  logic [PW-1:0] pp_shift;

  // anything at or above the clamp saturates the result anyway
  assign clamped  = (dividend > awrs_pkg::SAT_DIVIDEND) ? awrs_pkg::SAT_DIVIDEND : dividend;
  assign done     = done_r;
  assign quotient = QW'(acc_r[PW-1:awrs_pkg::RECIP_SHIFT]);

  always_comb begin
    m_part = step_r[0] ? {1'b0, awrs_pkg::RECIP_CONST[42:22]} : awrs_pkg::RECIP_CONST[21:0];
    y_part = step_r[1] ? y_r[41:21] : y_r[20:0];
    pp     = {21'b0, m_part} * {22'b0, y_part};
    case (step_r)
      2'd0:    pp_shift = PW'(pp);
      2'd1:    pp_shift = PW'(pp) << 22;
      2'd2:    pp_shift = PW'(pp) << 21;
      default: pp_shift = PW'(pp) << 43;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      y_r   <= clamped[45:4];
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/awrs_back.sv -----
`default_nettype none
module awrs_back #(
  parameter int MAX_DEPTH = 64,
  parameter int MAX_WIDTH = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_valid,
  input  wire awrs_pkg::job_t  job,
  output logic                 pop,
  input  wire awrs_pkg::cfg_t  cfg,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output awrs_pkg::out_item_t  out_data
);

  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int ZW        = $clog2(MAX_DEPTH);
  localparam int SW        = awrs_pkg::SLOT_W;
  localparam int AW        = SW + XW + ZW;
  localparam int MEM_DEPTH = awrs_pkg::WIN_PLANES << (XW + ZW);
  localparam int SUM_W     = awrs_pkg::SUM_W;
  localparam int ACC_W     = awrs_pkg::ACC_W;
  localparam int QW        = awrs_pkg::QUO_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WR   = 3'd1;
  localparam logic [2:0] ST_TAPS = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  awrs_pkg::job_t job_r;

  logic signed [31:0] mem [MEM_DEPTH];
  logic signed [31:0] rd_data_r;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               mem_we;

  logic [awrs_pkg::TAP_W-1:0] t_r;
  awrs_pkg::tap_info_t        info;
  logic [3:0]                 j;
  logic [4:0]                 slot_sum;
  logic [SW-1:0]              slot_rd;
  logic signed [8:0]          koff, xo, zo;
  logic                       plane_ok, x_ok, z_ok, mask, issue;

  logic                       s1_valid_r, s1_mask_r, s2_valid_r;
  awrs_pkg::tap_kind_t        s1_kind_r, s2_kind_r;
  logic [2:0]                 s1_k_r;
  logic signed [SUM_W-1:0]    prod_r, ts_r, xs_r, zs_r;

  logic [2:0]                 m_r;
  logic signed [SUM_W-1:0]    sel_sum;
  logic [31:0]                sel_b;
  logic signed [25:0]         a_op;
  logic signed [32:0]         b_op;
  logic signed [58:0]         mp_r;
  logic                       mp_valid_r, mp_hi_r, mp_sub_r;
  logic signed [ACC_W-1:0]    mp_ext, mp_shift, n_r;

  logic                       pos_over, neg_over, neg_r, div_start, div_done;
  logic [63:0]                mag;
  logic [QW-1:0]              div_in, quo;
  logic signed [31:0]         res_r, res_div;

  assign info     = awrs_pkg::tap_info(t_r);
  assign j        = (info.kind == awrs_pkg::KIND_TIME) ?
                    (info.neg ? 4'(awrs_pkg::HALF_ORDER) + {1'b0, info.k}
                              : 4'(awrs_pkg::HALF_ORDER) - {1'b0, info.k})
                    : 4'(awrs_pkg::HALF_ORDER);
  assign slot_sum = {1'b0, job_r.slot} + 5'(awrs_pkg::WIN_PLANES) - {1'b0, j};
  assign slot_rd  = (slot_sum >= 5'(awrs_pkg::WIN_PLANES)) ?
                    SW'(slot_sum - 5'(awrs_pkg::WIN_PLANES)) : SW'(slot_sum);
  assign koff     = $signed({6'b0, info.k});
  assign xo       = (info.kind == awrs_pkg::KIND_X) ?
                    (info.neg ? $signed({2'b0, job_r.x}) - koff : $signed({2'b0, job_r.x}) + koff)
                    : $signed({2'b0, job_r.x});
  assign zo       = (info.kind == awrs_pkg::KIND_Z) ?
                    (info.neg ? $signed({2'b0, job_r.z}) - koff : $signed({2'b0, job_r.z}) + koff)
                    : $signed({2'b0, job_r.z});
  assign plane_ok = (job_r.plane >= {13'b0, j}) &&
                    ((job_r.plane - {13'b0, j}) < {1'b0, cfg.planes});
  assign x_ok     = !xo[8] && (xo < $signed({2'b0, cfg.width}));
  assign z_ok     = !zo[8] && (zo < $signed({2'b0, cfg.depth}));

  always_comb begin
    unique case (info.kind)
      awrs_pkg::KIND_TIME: mask = plane_ok;
      awrs_pkg::KIND_X:    mask = x_ok;
      awrs_pkg::KIND_Z:    mask = z_ok;
      default:             mask = 1'b1;
    endcase
  end

  assign issue   = (state_r == ST_TAPS) && (t_r < 5'(awrs_pkg::NUM_TAPS));
  assign rd_addr = {slot_rd, XW'(xo), ZW'(zo)};
  assign wr_addr = {job_r.slot, XW'(job_r.x), ZW'(job_r.z)};
  assign mem_we  = (state_r == ST_WR);

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= job_r.sample;
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    case (m_r[2:1])
      2'd0:    begin sel_sum = ts_r; sel_b = job_r.slowness; end
      2'd1:    begin sel_sum = xs_r; sel_b = cfg.inv_dx;     end
      default: begin sel_sum = zs_r; sel_b = cfg.inv_dz;     end
    endcase
    a_op = m_r[0] ? 26'($signed(sel_sum[SUM_W-1:25])) : $signed({1'b0, sel_sum[24:0]});
    b_op = $signed({1'b0, sel_b});
  end

  assign mp_ext   = ACC_W'(mp_r);
  assign mp_shift = mp_hi_r ? (mp_ext <<< 25) : mp_ext;

  assign pos_over  = !n_r[ACC_W-1] && (n_r[ACC_W-1:63] != '0);
  assign neg_over  = n_r[ACC_W-1] && (n_r[ACC_W-1:63] != '1);
  assign mag       = n_r[ACC_W-1] ? (64'd0 - n_r[63:0]) : n_r[63:0];
  assign div_in    = mag[63:16] + QW'(awrs_pkg::ROUND_CONST);
  assign div_start = (state_r == ST_FIN) && !pos_over && !neg_over;

  always_comb begin
    if (!neg_r) begin
      res_div = (quo > QW'(32'h7fffffff)) ? 32'sh7fffffff : $signed(quo[31:0]);
    end else begin
      res_div = (quo > QW'(33'h080000000)) ? 32'sh80000000 : $signed(32'd0 - quo[31:0]);
    end
  end

  awrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quotient (quo)
  );

  assign pop = (state_r == ST_IDLE) && job_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (job_valid) state_nxt = ST_WR;
      ST_WR:   state_nxt = job_r.has_result ? ST_TAPS : ST_IDLE;
      ST_TAPS: begin
        if (t_r == 5'(awrs_pkg::NUM_TAPS) && !s1_valid_r && !s2_valid_r) state_nxt = ST_MUL;
      end
      ST_MUL:  if (m_r == 3'd6 && !mp_valid_r) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = (pos_over || neg_over) ? ST_DONE : ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      mp_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r;
      mp_valid_r <= (state_r == ST_MUL) && (m_r < 3'd6);
      if (state_r == ST_DONE && !out_valid) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= job;
    s1_mask_r <= mask;
    s1_kind_r <= info.kind;
    s1_k_r    <= info.k;
    s2_kind_r <= s1_kind_r;
    prod_r    <= (s1_mask_r ? rd_data_r : 32'sd0) * awrs_pkg::tap_weight(s1_k_r);
    mp_r      <= a_op * b_op;
    mp_hi_r   <= m_r[0];
    mp_sub_r  <= (m_r[2:1] != 2'd0);
    if (state_r == ST_WR) begin
      t_r  <= '0;
      m_r  <= '0;
      ts_r <= '0;
      xs_r <= '0;
      zs_r <= '0;
      n_r  <= '0;
    end else begin
      if (issue) t_r <= t_r + 5'd1;
      if (s2_valid_r) begin
        case (s2_kind_r)
          awrs_pkg::KIND_TIME: ts_r <= ts_r + prod_r;
          awrs_pkg::KIND_X:    xs_r <= xs_r + prod_r;
          awrs_pkg::KIND_Z:    zs_r <= zs_r + prod_r;
          default: begin
            ts_r <= ts_r + prod_r;
            xs_r <= xs_r + prod_r;
            zs_r <= zs_r + prod_r;
          end
        endcase
      end
      if (state_r == ST_MUL && m_r < 3'd6) m_r <= m_r + 3'd1;
      if (mp_valid_r) n_r <= mp_sub_r ? n_r - mp_shift : n_r + mp_shift;
    end
    if (state_r == ST_FIN) begin
      neg_r <= n_r[ACC_W-1];
      if (pos_over) res_r <= 32'sh7fffffff;
      else if (neg_over) res_r <= 32'sh80000000;
    end
    if (state_r == ST_DIV && div_done) res_r <= res_div;
    if (state_r == ST_DONE && !out_valid) begin
      out_data.residual   <= res_r;
      out_data.last_point <= job_r.last;
    end
  end

endmodule
`default_nettype wire

// ----- design/acoustic_wave_residual_stencil.sv -----
// tenth-order acoustic wave residual over a streamed volume: samples enter in raster order
// (plane, then x, then z) and each one from the sixth plane on yields the residual of the
// point five planes back. an item that yields no result is only written into the window
// memory; an item with a result also makes 31 tap reads through the single read port of
// the 11-plane window memory, drains the tap pipe, forms 6 split 26x33 products for the
// wide sum and runs a 4-step reciprocal multiply for the rounded divide (a saturated
// result skips it). the back end waits while a result sits unaccepted at the output. a
// 4-entry request queue lets inputs be taken while the back end works. the window needs no
// clearing pass after reset: taps of planes before the volume or past its end read as zero
// by position alone.
`default_nettype none
module acoustic_wave_residual_stencil #(
  parameter int MAX_DEPTH = 64,
  parameter int MAX_WIDTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire awrs_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output awrs_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [awrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                     cfg_data
);

  logic            q_full, push, pop, not_empty;
  awrs_pkg::job_t  push_job, head;
  awrs_pkg::cfg_t  cfg;

  awrs_front #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job),
    .cfg       (cfg)
  );

  awrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  awrs_back #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (not_empty),
    .job       (head),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- sim/acoustic_wave_residual_stencil_test.sv -----
`default_nettype none
module acoustic_wave_residual_stencil_test;
  timeunit 1ns;
  timeprecision 1ps;
  import awrs_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 250;
  localparam int TARGET_ITEMS = 1450;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  class residual_scoreboard;
    int win[WIN_PLANES][64][64];
    int unsigned zp, xp, tp;
    bit [6:0] dcnt, wcnt;
    bit [15:0] tcnt;
    bit [31:0] idz, idx;
    out_item_t residual_q[$];
    int mismatches;
    int checked;

    function new();
      foreach (win[p, x, z]) win[p][x][z] = 0;
      zp = 0; xp = 0; tp = 0;
      dcnt = 64; wcnt = 64; tcnt = 1;
      idz = 32'h10000; idx = 32'h10000;
      mismatches = 0;
      checked = 0;
    endfunction

    function int unsigned depth_used();
      return dcnt < 1 ? 1 : (dcnt > 64 ? 64 : dcnt);
    endfunction

    function int unsigned width_used();
      return wcnt < 1 ? 1 : (wcnt > 64 ? 64 : wcnt);
    endfunction

    function int unsigned planes_used();
      return tcnt < 1 ? 1 : tcnt;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] i, logic [31:0] v);
      case (i)
        REG_DEPTH: dcnt = v[6:0];
        REG_WIDTH: wcnt = v[6:0];
        REG_TIME: tcnt = v[15:0];
        REG_INV_DZ: idz = v;
        REG_INV_DX: idx = v;
        default: ;
      endcase
      if (i == REG_DEPTH || i == REG_WIDTH || i == REG_TIME) begin
        zp = 0; xp = 0; tp = 0;
      end
    endfunction

    function longint tap(int p, int x, int z);
      if (p < 0 || p >= int'(planes_used())) return 0;
      if (x < 0 || x >= int'(width_used())) return 0;
      if (z < 0 || z >= int'(depth_used())) return 0;
      return win[p % WIN_PLANES][x][z];
    endfunction

    function longint weight(int k);
      case (k)
        0: return -73766;
        1: return 42000;
        2: return -6000;
        3: return 1000;
        4: return -125;
        default: return 8;
      endcase
    endfunction

    function void note_input(in_item_t it);
      int unsigned d, w, t;
      int q, xi, zi;
      longint ts, xs, zs;
      logic signed [127:0] a, b, n;
      logic [127:0] m, quo;
      out_item_t e;
      d = depth_used(); w = width_used(); t = planes_used();
      win[tp % WIN_PLANES][xp][zp] = (tp >= t) ? 0 : it.sample;
      if (tp >= HALF_ORDER) begin
        q = tp - HALF_ORDER; xi = xp; zi = zp;
        ts = weight(0) * tap(q, xi, zi);
        xs = ts;
        zs = ts;
        for (int k = 1; k <= HALF_ORDER; k++) begin
          ts += weight(k) * (tap(q - k, xi, zi) + tap(q + k, xi, zi));
          xs += weight(k) * (tap(q, xi - k, zi) + tap(q, xi + k, zi));
          zs += weight(k) * (tap(q, xi, zi - k) + tap(q, xi, zi + k));
        end
        a = ts; b = {96'd0, it.slowness_term}; n = a * b;
        a = xs; b = {96'd0, idx}; n = n - a * b;
        a = zs; b = {96'd0, idz}; n = n - a * b;
        m = (n < 0) ? -n : n;
        quo = (m + 128'd825753600) / 128'd1651507200;
        if (n >= 0) e.residual = (quo > 128'h7fffffff) ? 32'h7fffffff : quo[31:0];
        else e.residual = (quo > 128'h80000000) ? 32'h80000000 : -quo[31:0];
        e.last_point = (q == int'(t - 1) && xp == w - 1 && zp == d - 1);
        residual_q.push_back(e);
      end
      zp++;
      if (zp >= d) begin
        zp = 0;
        xp++;
        if (xp >= w) begin
          xp = 0;
          tp++;
          if (tp >= t + HALF_ORDER) tp = 0;
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (residual_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result residual=%h last=%b", got.residual, got.last_point);
        return;
      end
      e = residual_q.pop_front();
      checked++;
      if (got.residual !== e.residual || got.last_point !== e.last_point) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %0d: expected residual=%h last=%b, got residual=%h last=%b",
                   checked, e.residual, e.last_point, got.residual, got.last_point);
      end
    endfunction

    function int pending();
      return residual_q.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  residual_scoreboard sb = new();
  int cycles = 0;
  int items_sent = 0;
  int volumes = 0;
  bit hold_req = 0;
  bit calm = 0;

  acoustic_wave_residual_stencil dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles % 512 == 0) calm = ($urandom % 3 == 0);
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL acoustic_wave_residual_stencil");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold;
    int r;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (hold_req && hold == 0) begin
        hold = 3000;
        hold_req = 0;
      end
      if (hold == 0 && !calm) begin
        r = $urandom % 100;
        if (r < 15) hold = $urandom_range(1, 3);
        else if (r < 17) hold = $urandom_range(20, 200);
      end
      if (hold > 0) begin
        out_ready <= 0;
        hold--;
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic send_request(in_item_t d);
    int r;
    int gap;
    in_valid <= 1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(d);
    items_sent++;
    gap = 0;
    if (!calm) begin
      r = $urandom % 100;
      if (r < 20) gap = $urandom_range(1, 3);
      else if (r < 22) gap = $urandom_range(20, 150);
    end
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] i, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= i;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(i, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_volume(logic [6:0] d, logic [6:0] w, logic [15:0] t,
                            logic [31:0] dz, logic [31:0] dx);
    wait_drained();
    reg_write(REG_INV_DZ, dz);
    reg_write(REG_INV_DX, dx);
    reg_write(REG_DEPTH, {25'd0, d});
    reg_write(REG_WIDTH, {25'd0, w});
    reg_write(REG_TIME, {16'd0, t});
    volumes++;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom % 5)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
      2: return ($urandom % 2) ? 32'h7fffffff : 32'h80000000;
      3: return 0;
      default: return 32'($signed($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom % 5)
      0: return $urandom;
      1: return 0;
      2: return 32'hffffffff;
      default: return $urandom_range(1, 8 * 65536);
    endcase
  endfunction

  task automatic send_volume(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.sample = rand_sample();
      it.slowness_term = rand_scale();
      send_request(it);
    end
  endtask

  initial begin
    in_item_t it;
    int unsigned d, w, t, total, n;
    int phase;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single point volume with the extreme values
    set_volume(1, 1, 1, 32'hffffffff, 32'hffffffff);
    it = '{sample: 32'h7fffffff, slowness_term: 32'hffffffff}; send_request(it);
    it = '{sample: 32'h80000000, slowness_term: 32'h0}; send_request(it);
    it = '{sample: 32'h80000000, slowness_term: 32'hffffffff}; send_request(it);
    it = '{sample: 32'h7fffffff, slowness_term: 32'h1}; send_request(it);
    it = '{sample: 32'h12345678, slowness_term: 32'h10000}; send_request(it);
    it = '{sample: 32'h7fffffff, slowness_term: 32'hffffffff}; send_request(it);
    // two planes, zero clamps to one, unknown index ignored
    set_volume(2, 0, 2, 32'h0, 32'h10000);
    reg_write(REG_UNUSED, 32'hffffffff);
    for (int i = 0; i < 14; i++) begin
      it.sample = (i % 2) ? 32'h80000000 : 32'h7fffffff;
      it.slowness_term = (i % 3) ? 32'hffffffff : 32'h0;
      send_request(it);
    end

    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      phase++;
      if (phase == 3) begin
        set_volume(64, 1, 1, rand_scale(), rand_scale());
        hold_req = 1;
        send_volume(64 * 6);
        continue;
      end
      if (phase == 6) begin
        set_volume(0, 127, 0, rand_scale(), rand_scale());
        send_volume(64 * 6);
        continue;
      end
      if (phase == 9) begin
        set_volume(1, 1, 16'hffff, rand_scale(), rand_scale());
        send_volume(40);
        continue;
      end
      d = $urandom_range(1, 5);
      w = $urandom_range(1, 5);
      t = $urandom_range(1, 4);
      if ($urandom % 10 == 0) d = $urandom_range(11, 14);
      if ($urandom % 10 == 0) w = $urandom_range(11, 14);
      set_volume(d[6:0], w[6:0], t[15:0], rand_scale(), rand_scale());
      if ($urandom % 6 == 0) reg_write(REG_UNUSED + 3'($urandom % 3), $urandom);
      total = d * w * (t + HALF_ORDER);
      n = total;
      if ($urandom % 8 == 0) n = $urandom_range(1, total);
      else if ($urandom % 5 == 0) n = total * 2;
      if (n > TARGET_ITEMS - items_sent) n = TARGET_ITEMS - items_sent;
      send_volume(n);
    end

    wait_drained();
    $display("checked %0d residuals over %0d volume settings from %0d input requests",
             sb.checked, volumes, items_sent);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS acoustic_wave_residual_stencil");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("FAIL acoustic_wave_residual_stencil");
    end
    $finish;
  end
endmodule
`default_nettype wire
